>>> hdl/cdc_pkg.sv
// ----------------------------------------------------------------------------
// cdc_pkg
// Shared types, constants and calendar functions for the date counter.
// ----------------------------------------------------------------------------
package cdc_pkg;

    localparam logic [2:0] OP_NEXT      = 3'd0;
    localparam logic [2:0] OP_PREV      = 3'd1;
    localparam logic [2:0] OP_LOAD      = 3'd2;
    localparam logic [2:0] OP_PEEK_FWD  = 3'd3;
    localparam logic [2:0] OP_PEEK_BACK = 3'd4;

    localparam logic [13:0] BASE_YEAR = 14'd1900;
    localparam logic [13:0] LAST_YEAR = 14'd16383;
    localparam logic [4:0]  BASE_R25  = 5'd0;      // 1900 mod 25

    // floor(y / 25) = (y * RECIP_25) >> RECIP_SHIFT for every 14-bit y
    localparam logic [12:0] RECIP_25    = 13'd5243;
    localparam int          RECIP_SHIFT = 17;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [4:0]  r25;     // year mod 25
    } date_t;

    typedef struct packed {
        date_t dt;
        logic  ok;
    } step_res_t;

    // divisible by 4, and not by 100 unless by 400 (400 = 16 * 25)
    function automatic logic leap_of(input logic [13:0] y, input logic [4:0] r25);
        logic is_leap;
        is_leap = (y[1:0] == 2'd0) && ((r25 != 5'd0) || (y[3:0] == 4'd0));
        return is_leap;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4,
            4'd6,
            4'd9,
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

>>> hdl/cdc_if.sv
// ----------------------------------------------------------------------------
// cdc_if
// Request and response channels of the calendar date counter.
// ----------------------------------------------------------------------------
interface cdc_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [4:0]  load_day;
    logic [3:0]  load_month;
    logic [13:0] load_year;
    logic [11:0] offset_count;

    modport source (
        output valid, opcode, load_day, load_month, load_year, offset_count,
        input  ready
    );
    modport sink (
        input  valid, opcode, load_day, load_month, load_year, offset_count,
        output ready
    );
endinterface

interface cdc_rsp_if;
    logic        valid;
    logic        ready;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic        accepted;
    logic        at_default;

    modport source (
        output valid, day, month, year, accepted, at_default,
        input  ready
    );
    modport sink (
        input  valid, day, month, year, accepted, at_default,
        output ready
    );
endinterface

>>> hdl/cdc_day_step.sv
// ----------------------------------------------------------------------------
// cdc_day_step
// Shared one-day step unit: moves a date forward or back by one day.
// ----------------------------------------------------------------------------
module cdc_day_step (
    input  cdc_pkg::date_t     cur,
    input  logic               dir_back,
    output cdc_pkg::step_res_t res
);
    import cdc_pkg::*;

    logic       leap;
    logic [4:0] len_cur;
    logic [4:0] len_prev;
    logic [3:0] month_dec;

    assign leap      = leap_of(cur.year, cur.r25);
    assign len_cur   = month_len(cur.month, leap);
    assign month_dec = cur.month - 4'd1;
    assign len_prev  = month_len(month_dec, leap);

    always_comb
    begin
        res.dt = cur;
        res.ok = 1'b1;
        if (!dir_back)
        begin
            if (cur.day < len_cur)
            begin
                res.dt.day = cur.day + 5'd1;
            end
            else if (cur.month < 4'd12)
            begin
                res.dt.month = cur.month + 4'd1;
                res.dt.day   = 5'd1;
            end
            else if (cur.year == LAST_YEAR)
            begin
                res.ok = 1'b0;
            end
            else
            begin
                res.dt.year  = cur.year + 14'd1;
                res.dt.month = 4'd1;
                res.dt.day   = 5'd1;
                res.dt.r25   = (cur.r25 == 5'd24) ? 5'd0 : cur.r25 + 5'd1;
            end
        end
        else
        begin
            if (cur.day > 5'd1)
            begin
                res.dt.day = cur.day - 5'd1;
            end
            else if (cur.month > 4'd1)
            begin
                res.dt.month = month_dec;
                res.dt.day   = len_prev;
            end
            else if (cur.year <= BASE_YEAR)
            begin
                res.ok = 1'b0;
            end
            else
            begin
                res.dt.year  = cur.year - 14'd1;
                res.dt.month = 4'd12;
                res.dt.day   = 5'd31;
                res.dt.r25   = (cur.r25 == 5'd0) ? 5'd24 : cur.r25 - 5'd1;
            end
        end
    end

endmodule

>>> hdl/cdc_year_res.sv
// ----------------------------------------------------------------------------
// cdc_year_res
// Pipelined year mod 25 unit: reciprocal multiply, register, then correct-free subtract.
// ----------------------------------------------------------------------------
module cdc_year_res (
    input  logic        clk,
    input  logic [13:0] year,
    output logic [4:0]  r25
);
    import cdc_pkg::*;

    logic [26:0] prod;
    logic [9:0]  q_reg;
    logic [13:0] y_reg;
    logic [14:0] q_times_25;
    logic [14:0] diff;

    assign prod = 27'(year) * 27'(RECIP_25);

    always_ff @(posedge clk)
    begin
        q_reg <= prod[RECIP_SHIFT +: 10];
        y_reg <= year;
    end

    assign q_times_25 = {1'b0, q_reg, 4'd0} + {2'd0, q_reg, 3'd0} + {5'd0, q_reg};
    assign diff       = {1'b0, y_reg} - q_times_25;
    assign r25        = diff[4:0];

endmodule

>>> hdl/calendar_date_counter.sv
// ----------------------------------------------------------------------------
// calendar_date_counter
// Gregorian date counter: step, load and peek by offset with a shared unit.
//
//   channel  dir  payload
//   req      in   opcode, load_day, load_month, load_year, offset_count
//   rsp      out  day, month, year, accepted, at_default
//
// One request at a time; req.ready is high only while the sequencer is idle.
// Next/previous day: one day step; load: S_RES, then S_LOAD with the mod-25
// unit; peek by N days: N day steps (stops early on saturation). Each request
// is accepted in S_IDLE and ends in S_DONE, which writes the rsp register.
// Reset puts the held date at 1900-01-01. A stalled rsp holds the finished
// transaction; the next request is taken while it waits.
// ----------------------------------------------------------------------------
module calendar_date_counter (
    input  logic   clk,
    input  logic   rst_n,
    cdc_req_if.sink   req,
    cdc_rsp_if.source rsp
);
    import cdc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_STEP = 3'd1;
    localparam logic [2:0] S_RES  = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]  state_reg, state_next;
    date_t       held_reg, held_next;
    date_t       work_reg, work_next;
    logic [11:0] cnt_reg, cnt_next;
    logic        back_reg, back_next;
    logic        commit_reg, commit_next;
    logic        ok_reg, ok_next;
    logic [4:0]  ld_day_reg, ld_day_next;
    logic [3:0]  ld_month_reg, ld_month_next;
    logic [13:0] ld_year_reg, ld_year_next;

    logic        out_valid_reg, out_valid_next;
    date_t       out_dt_reg, out_dt_next;
    logic        out_ok_reg, out_ok_next;

    step_res_t   step_res;
    logic [4:0]  ld_r25;
    logic        ld_valid;
    logic        accept;
    logic        out_free;

    cdc_day_step u_step (
        .cur      (work_reg),
        .dir_back (back_reg),
        .res      (step_res)
    );

    cdc_year_res u_res (
        .clk  (clk),
        .year (ld_year_reg),
        .r25  (ld_r25)
    );

    assign ld_valid = (ld_year_reg >= BASE_YEAR) && (ld_month_reg >= 4'd1)
                   && (ld_month_reg <= 4'd12) && (ld_day_reg >= 5'd1)
                   && (ld_day_reg <= month_len(ld_month_reg, leap_of(ld_year_reg, ld_r25)));

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        work_next      = work_reg;
        cnt_next       = cnt_reg;
        back_next      = back_reg;
        commit_next    = commit_reg;
        ok_next        = ok_reg;
        ld_day_next    = ld_day_reg;
        ld_month_next  = ld_month_reg;
        ld_year_next   = ld_year_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_dt_next    = out_dt_reg;
        out_ok_next    = out_ok_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    work_next     = held_reg;
                    ok_next       = 1'b1;
                    ld_day_next   = req.load_day;
                    ld_month_next = req.load_month;
                    ld_year_next  = req.load_year;
                    commit_next   = (req.opcode == OP_NEXT) || (req.opcode == OP_PREV)
                                 || (req.opcode == OP_LOAD);
                    back_next     = (req.opcode == OP_PREV) || (req.opcode == OP_PEEK_BACK);
                    case (req.opcode)
                        OP_NEXT,
                        OP_PREV:
                        begin
                            cnt_next   = 12'd1;
                            state_next = S_STEP;
                        end
                        OP_PEEK_FWD,
                        OP_PEEK_BACK:
                        begin
                            cnt_next   = req.offset_count;
                            state_next = (req.offset_count == 12'd0) ? S_DONE : S_STEP;
                        end
                        OP_LOAD:
                        begin
                            state_next = S_RES;
                        end
                        default:
                        begin
                            ok_next    = 1'b0;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_STEP:
            begin
                if (!step_res.ok)
                begin
                    ok_next    = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    work_next = step_res.dt;
                    cnt_next  = cnt_reg - 12'd1;
                    if (cnt_reg == 12'd1)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_RES:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (ld_valid)
                begin
                    work_next.day   = ld_day_reg;
                    work_next.month = ld_month_reg;
                    work_next.year  = ld_year_reg;
                    work_next.r25   = ld_r25;
                end
                else
                begin
                    ok_next = 1'b0;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_dt_next    = work_reg;
                    out_ok_next    = ok_reg;
                    if (commit_reg)
                    begin
                        held_next = work_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            held_reg.day   <= 5'd1;
            held_reg.month <= 4'd1;
            held_reg.year  <= BASE_YEAR;
            held_reg.r25   <= BASE_R25;
            out_valid_reg  <= 1'b0;
            cnt_reg        <= 12'd0;
            back_reg       <= 1'b0;
            commit_reg     <= 1'b0;
            ok_reg         <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            back_reg      <= back_next;
            commit_reg    <= commit_next;
            ok_reg        <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        ld_day_reg   <= ld_day_next;
        ld_month_reg <= ld_month_next;
        ld_year_reg  <= ld_year_next;
        out_dt_reg   <= out_dt_next;
        out_ok_reg   <= out_ok_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.day        = out_dt_reg.day;
    assign rsp.month      = out_dt_reg.month;
    assign rsp.year       = out_dt_reg.year;
    assign rsp.accepted   = out_ok_reg;
    assign rsp.at_default = (out_dt_reg.day == 5'd1) && (out_dt_reg.month == 4'd1)
                         && (out_dt_reg.year == BASE_YEAR);

endmodule
